@@ src/b64d_pkg.sv @@
// Package for the base64 bitmap decoder: payload types, the queued item
// type, field widths and the alphabet lookup. Depends on nothing.
package b64d_pkg;

  localparam int CharW  = 8;
  localparam int SextW  = 6;
  localparam int CountW = 14;
  localparam int AddrW  = 13;
  localparam int ByteW  = 8;

  localparam logic [CountW-1:0] LimitReset = 14'd8192;
  localparam logic [CountW-1:0] CountMax   = {CountW{1'b1}};

  localparam logic [CharW-1:0] CharNul = 8'h00;
  localparam logic [CharW-1:0] CharPad = 8'h3D;  // '='

  // Position of a character inside its group of four
  typedef enum logic [1:0] {
    PhFirst  = 2'd0,
    PhSecond = 2'd1,
    PhThird  = 2'd2,
    PhFourth = 2'd3
  } phase_e;

  typedef struct packed {
    logic [CharW-1:0] in_char;
    logic             last;
  } in_pld_t;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic [AddrW-1:0] out_addr;
  } out_pld_t;

  typedef struct packed {
    logic [CountW-1:0] byte_limit;
  } cfg_pld_t;

  // Classified character as it travels from front to back
  typedef struct packed {
    logic [SextW-1:0] sextet;
    logic             is_nul;
    logic             is_pad;
    logic             last;
  } item_t;

  // Queue status seen by the front and the back
  typedef struct packed {
    logic full;
    logic valid;
  } q_stat_t;

  // Map one character to its 6-bit value; anything off the alphabet is 0
  function automatic logic [SextW-1:0] sextet_of(input logic [CharW-1:0] c);
    logic [CharW-1:0] v;
    v = '0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      v = c - 8'h41;
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      v = c - 8'h61 + 8'd26;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30 + 8'd52;
    end else if (c == 8'h2B) begin
      v = 8'd62;
    end else if (c == 8'h2F) begin
      v = 8'd63;
    end
    return v[SextW-1:0];
  endfunction

endpackage

@@ src/b64d_stream_if.sv @@
// Valid/ready channel carrying one payload per transfer.
// Payload types come from b64d_pkg.
interface b64d_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ src/b64d_front.sv @@
// Front end: takes characters from the input channel, classifies them and
// pushes them into the queue. Depends on b64d_pkg and b64d_stream_if.
module b64d_front import b64d_pkg::*; (
  b64d_stream_if.sink in_i,
  input  q_stat_t     q_stat_i,
  output logic        push_o,
  output item_t       item_o
);

  // Accept whenever the queue has room
  assign in_i.ready = ~q_stat_i.full;
  assign push_o     = in_i.valid & ~q_stat_i.full;

  // Classify the character
  always_comb begin
    item_o.sextet = sextet_of(in_i.data.in_char);
    item_o.is_nul = (in_i.data.in_char == CharNul);
    item_o.is_pad = (in_i.data.in_char == CharPad);
    item_o.last   = in_i.data.last;
  end

endmodule

@@ src/b64d_queue.sv @@
// Two-entry queue of classified characters between front and back.
// Depends on b64d_pkg.
module b64d_queue import b64d_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  item_t   item_i,
  input  logic    pop_i,
  output item_t   item_o,
  output q_stat_t stat_o
);

  item_t      mem_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  assign stat_o.full  = (cnt_q == 2'd2);
  assign stat_o.valid = (cnt_q != 2'd0);
  assign item_o       = mem_q[rd_q];

  // Advance pointers and fill count
  always_comb begin
    wr_d  = wr_q ^ push_i;
    rd_d  = rd_q ^ pop_i;
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store the pushed entry
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_o.full |-> !push_i)
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !stat_o.valid |-> !pop_i)
    else $error("pop from an empty queue");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("queue fill count out of range");

endmodule

@@ src/b64d_back.sv @@
// Back end: decoding state, byte limit register and output register.
// Depends on b64d_pkg and b64d_stream_if.
module b64d_back import b64d_pkg::*; #(
  parameter int MAX_BYTES = 8192
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  b64d_stream_if.sink   cfg_i,
  b64d_stream_if.source out_o,
  input  item_t       item_i,
  input  q_stat_t     q_stat_i,
  output logic        pop_o
);

  // Limit cap; bytes_q never goes past the 14-bit register range
  localparam logic [CountW-1:0] LimCap =
    CountW'((MAX_BYTES > int'(CountMax)) ? int'(CountMax) : MAX_BYTES);

  logic [CountW-1:0] limit_q;
  logic [CountW-1:0] limit;
  phase_e            phase_q, phase_d;
  logic [SextW-1:0]  held_q, held_d;
  logic [CountW-1:0] bytes_q, bytes_d, bytes_inc;
  logic              halted_q, halted_d;
  logic              emit;
  logic [ByteW-1:0]  byte_val;
  logic              out_valid_q;
  out_pld_t          out_q;
  logic              slot_free;

  // Take a register write in any cycle
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset;
    end else if (cfg_i.valid) begin
      limit_q <= cfg_i.data.byte_limit;
    end
  end

  assign limit     = (limit_q < LimCap) ? limit_q : LimCap;
  assign slot_free = ~out_valid_q | out_o.ready;
  assign pop_o     = q_stat_i.valid & slot_free;
  assign bytes_inc = bytes_q + 1'b1;

  // Decode one character: next state and the byte it may produce
  always_comb begin
    phase_d  = phase_q;
    held_d   = held_q;
    bytes_d  = bytes_q;
    halted_d = halted_q;
    emit     = 1'b0;
    byte_val = '0;
    if (!halted_q) begin
      if (bytes_q >= limit || item_i.is_nul) begin
        halted_d = 1'b1;
      end else begin
        unique case (phase_q)
          PhFirst: begin
            held_d  = item_i.sextet;
            phase_d = PhSecond;
          end
          PhSecond: begin
            byte_val = {held_q, item_i.sextet[5:4]};
            emit     = 1'b1;
            held_d   = item_i.sextet;
            phase_d  = PhThird;
          end
          PhThird: begin
            if (item_i.is_pad) begin
              halted_d = 1'b1;
            end else begin
              byte_val = {held_q[3:0], item_i.sextet[5:2]};
              emit     = 1'b1;
              held_d   = item_i.sextet;
              phase_d  = PhFourth;
            end
          end
          PhFourth: begin
            if (item_i.is_pad) begin
              halted_d = 1'b1;
            end else begin
              byte_val = {held_q[1:0], item_i.sextet};
              emit     = 1'b1;
              held_d   = '0;
              phase_d  = PhFirst;
            end
          end
          default: begin
            phase_d = PhFirst;
          end
        endcase
      end
    end
    if (emit) begin
      bytes_d = bytes_inc;
      if (bytes_inc >= limit) begin
        halted_d = 1'b1;
      end
    end
    // Drop all group state after the final character
    if (item_i.last) begin
      phase_d  = PhFirst;
      held_d   = '0;
      bytes_d  = '0;
      halted_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhFirst;
      held_q   <= '0;
      bytes_q  <= '0;
      halted_q <= 1'b0;
    end else if (pop_o) begin
      phase_q  <= phase_d;
      held_q   <= held_d;
      bytes_q  <= bytes_d;
      halted_q <= halted_d;
    end
  end

  // Output register: load on emit, hold until the transfer completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (slot_free) begin
      out_valid_q <= pop_o & emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && emit) begin
      out_q.out_byte <= byte_val;
      out_q.out_addr <= bytes_q[AddrW-1:0];
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  a_halt_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && halted_q |-> !emit)
    else $error("byte produced while halted");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && item_i.last |=> phase_q == PhFirst && bytes_q == '0 && !halted_q)
    else $error("state not cleared after final character");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && emit && !item_i.last |=> bytes_q == $past(bytes_q) + 1'b1)
    else $error("byte count did not advance with an emitted byte");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |=> out_valid_q && $stable(out_q))
    else $error("pending result overwritten");

endmodule

@@ src/base64_bitmap_decoder_core.sv @@
// Top level of the base64 bitmap decoder: front, queue and back.
// Depends on b64d_pkg, b64d_stream_if, b64d_front, b64d_queue, b64d_back.

// Decodes one base64 character per cycle into bitmap bytes with their
// addresses. A character is taken in every cycle that the queue has room;
// with the output side ready the block sustains one character per clock.
// A character passes through the queue and its byte through the output
// register. The second, third and fourth character of each group of four
// yield one byte each. A NUL, an '=' in the third or fourth position, or
// reaching byte_limit (capped at MAX_BYTES) stops decoding until a
// character flagged last, which returns the block to its start state.
// The byte_limit register is taken in any cycle and should only be
// changed while no characters are in flight.
module base64_bitmap_decoder_core import b64d_pkg::*; #(
  parameter int MAX_BYTES = 8192
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  b64d_stream_if.sink   in_i,
  b64d_stream_if.sink   cfg_i,
  b64d_stream_if.source out_o
);

  logic    push;
  logic    pop;
  item_t   push_item;
  item_t   pop_item;
  q_stat_t q_stat;

  b64d_front u_front (
    .in_i     (in_i),
    .q_stat_i (q_stat),
    .push_o   (push),
    .item_o   (push_item)
  );

  b64d_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .pop_i  (pop),
    .item_o (pop_item),
    .stat_o (q_stat)
  );

  b64d_back #(
    .MAX_BYTES (MAX_BYTES)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_i),
    .out_o    (out_o),
    .item_i   (pop_item),
    .q_stat_i (q_stat),
    .pop_o    (pop)
  );

endmodule

@@ verif/tb_base64_bitmap_decoder_core.sv @@
// Testbench for base64_bitmap_decoder_core: streams base64 strings with random
// idling on both sides, predicts every bitmap byte and checks each output transfer.
// Depends on b64d_pkg, b64d_stream_if and the decoder RTL.
module tb_base64_bitmap_decoder_core;
  import b64d_pkg::*;

  localparam int    MaxBytes   = 8192;
  localparam int    MaxGap     = 18;
  localparam int    QuietLimit = 4000;
  localparam string Alphabet   =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  logic clk_i;
  logic rst_ni;

  b64d_stream_if #(.payload_t(in_pld_t))  char_if ();
  b64d_stream_if #(.payload_t(cfg_pld_t)) limit_if ();
  b64d_stream_if #(.payload_t(out_pld_t)) byte_if ();

  base64_bitmap_decoder_core #(.MAX_BYTES(MaxBytes)) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (char_if),
    .cfg_i  (limit_if),
    .out_o  (byte_if)
  );

  // Decoder state as the testbench sees it
  logic [CountW-1:0] limit_q   = LimitReset;
  phase_e            phase_q   = PhFirst;
  logic [SextW-1:0]  held_q    = '0;
  logic [CountW-1:0] written_q = '0;
  logic              halted_q  = 1'b0;
  out_pld_t          pending_bytes[$];

  int err_cnt     = 0;
  int quiet_cnt   = 0;
  int chars_sent  = 0;
  int hold_cycles = 0;
  bit tx_fast     = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Map a character to its six-bit value; anything off the alphabet is zero
  function automatic logic [SextW-1:0] char_value(logic [CharW-1:0] c);
    for (int i = 0; i < 64; i++) begin
      if (Alphabet[i] == c) return SextW'(i);
    end
    return '0;
  endfunction

  function automatic logic [CharW-1:0] rand_b64();
    return Alphabet[$urandom_range(0, 63)];
  endfunction

  // Advance the decoder state by one character and queue the byte it yields
  function automatic void decode_char(in_pld_t it);
    logic [SextW-1:0]  v;
    logic [CountW-1:0] cap;
    out_pld_t          res;
    logic              emit;
    v    = char_value(it.in_char);
    cap  = (limit_q > CountW'(MaxBytes)) ? CountW'(MaxBytes) : limit_q;
    res  = '0;
    emit = 1'b0;
    if (!halted_q) begin
      if (written_q >= cap || it.in_char == CharNul) begin
        halted_q = 1'b1;
      end else begin
        case (phase_q)
          PhFirst: begin
            held_q  = v;
            phase_q = PhSecond;
          end
          PhSecond: begin
            res.out_byte = {held_q, v[5:4]};
            emit         = 1'b1;
            held_q       = v;
            phase_q      = PhThird;
          end
          PhThird: begin
            if (it.in_char == CharPad) begin
              halted_q = 1'b1;
            end else begin
              res.out_byte = {held_q[3:0], v[5:2]};
              emit         = 1'b1;
              held_q       = v;
              phase_q      = PhFourth;
            end
          end
          default: begin
            if (it.in_char == CharPad) begin
              halted_q = 1'b1;
            end else begin
              res.out_byte = {held_q[1:0], v};
              emit         = 1'b1;
              held_q       = '0;
              phase_q      = PhFirst;
            end
          end
        endcase
      end
    end
    if (emit) begin
      res.out_addr  = written_q[AddrW-1:0];
      pending_bytes = {pending_bytes, res};
      written_q = written_q + 1'b1;
      if (written_q >= cap) halted_q = 1'b1;
    end
    // A flagged character returns the decoder to its start state
    if (it.last) begin
      phase_q   = PhFirst;
      held_q    = '0;
      written_q = '0;
      halted_q  = 1'b0;
    end
  endfunction

  // Watch every channel: check bytes, predict from characters, track the limit
  always @(posedge clk_i) begin : monitor
    out_pld_t want;
    out_pld_t got;
    quiet_cnt++;
    if (byte_if.valid && byte_if.ready) begin
      quiet_cnt = 0;
      got = byte_if.data;
      if (pending_bytes.size() == 0) begin
        $error("unexpected byte transfer: out_byte %0h out_addr %0d",
               got.out_byte, got.out_addr);
        err_cnt++;
      end else begin
        want = pending_bytes.pop_front();
        if (got.out_byte !== want.out_byte) begin
          $error("out_byte: expected %0h, actual %0h", want.out_byte, got.out_byte);
          err_cnt++;
        end
        if (got.out_addr !== want.out_addr) begin
          $error("out_addr: expected %0d, actual %0d", want.out_addr, got.out_addr);
          err_cnt++;
        end
      end
    end
    if (char_if.valid && char_if.ready) begin
      quiet_cnt = 0;
      decode_char(char_if.data);
    end
    if (limit_if.valid && limit_if.ready) begin
      quiet_cnt = 0;
      limit_q   = limit_if.data.byte_limit;
    end
  end

  // Drive ready with random stalls, fast stretches and requested long holds
  initial begin : receiver
    int stall;
    int served;
    bit fast;
    byte_if.ready <= 1'b0;
    served = 0;
    fast   = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (served % 32 == 0) fast = ($urandom_range(0, 2) == 0);
      if (hold_cycles > 0) begin
        byte_if.ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk_i);
        hold_cycles = 0;
      end
      stall = fast ? 0 : $urandom_range(0, MaxGap);
      if (stall > 0) begin
        byte_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      byte_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!byte_if.valid) @(posedge clk_i);
      served++;
    end
  end

  // Offer one character and hold it until the transfer
  task automatic send_char(logic [CharW-1:0] c, logic is_last);
    int gap;
    gap = tx_fast ? 0 : $urandom_range(0, MaxGap);
    if (gap > 0) begin
      char_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    char_if.valid <= 1'b1;
    char_if.data  <= in_pld_t'{in_char: c, last: is_last};
    @(posedge clk_i);
    while (!char_if.ready) @(posedge clk_i);
    chars_sent++;
  endtask

  task automatic send_text(string s, bit last_at_end);
    int i;
    for (i = 0; i < s.len(); i++) send_char(s[i], last_at_end && i == s.len() - 1);
  endtask

  // Drop valid and wait until every expected byte is out and the block is quiet
  task automatic settle();
    char_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_bytes.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_limit(logic [CountW-1:0] v);
    settle();
    limit_if.valid <= 1'b1;
    limit_if.data  <= cfg_pld_t'{byte_limit: v};
    @(posedge clk_i);
    while (!limit_if.ready) @(posedge clk_i);
    limit_if.valid <= 1'b0;
  endtask

  // One string: mostly well-formed, some noise, broken or unterminated
  task automatic send_random_string();
    int kind;
    int groups;
    int pad;
    int len;
    int cut;
    int i;
    logic [CharW-1:0] c;
    kind    = $urandom_range(0, 9);
    tx_fast = ($urandom_range(0, 3) == 0);
    if (kind <= 6) begin
      groups = $urandom_range(1, 6);
      pad    = $urandom_range(0, 2);
      for (i = 0; i < groups * 4; i++) begin
        c = (i >= groups * 4 - pad) ? CharPad : rand_b64();
        send_char(c, i == groups * 4 - 1);
      end
    end else if (kind == 7) begin
      // any byte at all, with stray last flags
      len = $urandom_range(1, 12);
      for (i = 0; i < len; i++) begin
        send_char(CharW'($urandom_range(0, 255)), i == len - 1 || $urandom_range(0, 9) == 0);
      end
    end else if (kind == 8) begin
      // terminator or pad at a random point, then trailing characters
      len = $urandom_range(2, 16);
      cut = $urandom_range(0, len - 2);
      for (i = 0; i < len; i++) begin
        c = rand_b64();
        if (i == cut) c = $urandom_range(0, 1) ? CharNul : CharPad;
        send_char(c, i == len - 1);
      end
    end else begin
      // no last flag: state carries into the next string
      len = $urandom_range(1, 7);
      for (i = 0; i < len; i++) send_char(rand_b64(), 1'b0);
    end
  endtask

  // Field extremes, pads in the second, third and fourth position, NUL, halted characters, last flag
  task automatic test_directed();
    tx_fast = 1'b0;
    send_text("TWFu+/z9", 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(CharPad, 1'b0);
    send_char(8'h80, 1'b0);
    send_char(CharPad, 1'b0);
    send_char("Q", 1'b0);
    send_char("x", 1'b1);
    send_text("0a", 1'b0);
    send_char(CharNul, 1'b0);
    send_char("A", 1'b1);
    send_char("A", 1'b1);
    send_char(CharNul, 1'b1);
    send_text("q/=", 1'b1);
  endtask

  // Small limits stop decoding early, some mid-group, a zero limit emits nothing
  task automatic test_byte_limit();
    int vals[$] = '{0, 1, 2, 3, 5};
    foreach (vals[i]) begin
      set_limit(CountW'(vals[i]));
      tx_fast = vals[i][0];
      send_text("TWFuTWFu", 1'b1);
    end
    set_limit(LimitReset);
  endtask

  // Hold the output off long enough for the block to fill and stall its input
  task automatic test_backpressure();
    settle();
    hold_cycles = 300;
    tx_fast     = 1'b1;
    send_text("SGVsbG8gd29ybGQhIFRoaXMgaXMgYSBsb25nIHN0cmluZyBvZiBieXRlcyE=", 1'b1);
  endtask

  // Random strings across several limit settings
  task automatic test_random();
    int p;
    int pick;
    int start;
    logic [CountW-1:0] v;
    for (p = 0; p < 8; p++) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) v = '0;
      else if (pick == 1) v = CountMax;
      else if (pick == 2) v = CountW'($urandom_range(0, CountMax));
      else v = CountW'($urandom_range(1, 40));
      set_limit(v);
      start = chars_sent;
      while (chars_sent - start < 100) send_random_string();
    end
  endtask

  // Oversized limit saturates: a long string runs on without an early halt
  task automatic test_cap();
    int i;
    set_limit(CountMax);
    tx_fast = 1'b1;
    for (i = 0; i < 160; i++) send_char(rand_b64(), 1'b0);
    send_char(rand_b64(), 1'b1);
    set_limit(LimitReset);
  endtask

  initial begin : watchdog
    @(posedge clk_i);
    while (quiet_cnt < QuietLimit) @(posedge clk_i);
    $error("no transfer for %0d cycles", QuietLimit);
    $display("tb_base64_bitmap_decoder_core NOT OK");
    $finish;
  end

  initial begin : main
    rst_ni         <= 1'b0;
    char_if.valid  <= 1'b0;
    char_if.data   <= '0;
    limit_if.valid <= 1'b0;
    limit_if.data  <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_byte_limit();
    test_backpressure();
    test_random();
    test_cap();
    settle();
    if (err_cnt == 0) begin
      $display("tb_base64_bitmap_decoder_core OK");
    end else begin
      $display("tb_base64_bitmap_decoder_core NOT OK");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/b64d_pkg.sv
src/b64d_stream_if.sv
src/b64d_front.sv
src/b64d_queue.sv
src/b64d_back.sv
src/base64_bitmap_decoder_core.sv
verif/tb_base64_bitmap_decoder_core.sv
